[sv/delay_multiply_fsk_demod_defines.svh]
// Assertion macros shared by the delay-multiply FSK demodulator RTL.
`ifndef DELAY_MULTIPLY_FSK_DEMOD_DEFINES_SVH
`define DELAY_MULTIPLY_FSK_DEMOD_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define DMFD_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dmfd assertion failed");

// Concurrent assertion on the block clock and reset.
`define DMFD_ASSERT(lbl, prop) `DMFD_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

[sv/dmfd_pkg.sv]
// Types and constants shared by the delay-multiply FSK demodulator.
`timescale 1ns / 1ps
`default_nettype none
package dmfd_pkg;

  localparam int Q15_W      = 16;
  localparam int PROD_W     = 2 * Q15_W;
  localparam int NUM_COEF   = 7;
  localparam int COEF_IDX_W = 3;

  typedef logic signed [Q15_W-1:0]  q15_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam q15_t COEF_RESET [NUM_COEF] = '{
    16'sd273, 16'sd707, 16'sd1393, 16'sd2232, 16'sd3058, 16'sd3666, 16'sd3889
  };

  // Per-cycle controls broadcast along the tap chain.
  typedef struct packed {
    logic shift;
    logic load_term;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[sv/dmfd_cell.sv]
// One FIR tap cell: product history entry, coefficient term and ripple partial sum.
`timescale 1ns / 1ps
`default_nettype none
module dmfd_cell import dmfd_pkg::*; #(
  parameter int ACC_W = 36
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cell_ctrl_t              ctrl_i,
  input  wire q15_t                    prod_i,
  input  wire q15_t                    coef_i,
  input  wire logic signed [ACC_W-1:0] sum_i,
  output      q15_t                    prod_o,
  output      logic signed [ACC_W-1:0] sum_o
);

  q15_t                    prod_q;
  prod_t                   term_q;
  prod_t                   term_d;
  logic signed [ACC_W-1:0] sum_q;
  logic signed [ACC_W-1:0] sum_d;

  assign term_d = PROD_W'(coef_i * prod_q);
  assign sum_d  = sum_i + ACC_W'(term_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else if (ctrl_i.shift) begin
      prod_q <= prod_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_term) begin
      term_q <= term_d;
    end
    sum_q <= sum_d;
  end

  assign prod_o = prod_q;
  assign sum_o  = sum_q;

endmodule
`default_nettype wire

[sv/delay_multiply_fsk_demod.sv]
// The product is registered on acceptance; S_MUL shifts it into the tap chain,
// S_TERM weights it, S_SUM sums and S_DONE registers it. Samples are accepted
// only in S_IDLE; the sum ripples one cell per cycle, so TAPS sets the item period.
// Reset (async, active low): sample and product histories zero, coefficients
// to defaults, output empty, controller idle.
`timescale 1ns / 1ps
`default_nettype none
`include "delay_multiply_fsk_demod_defines.svh"
module delay_multiply_fsk_demod import dmfd_pkg::*; #(
  parameter int TAPS        = 13,
  parameter int LAG         = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid,
  output      logic                                  s_axis_tready,
  // [SAMPLE_BITS-1:0] raw_sample, zero fill above
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  output      logic                                  m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // [15:0] demod_out
  output      logic [Q15_W-1:0]                      m_axis_tdata,
  input  wire logic                                  cfg_we_i,
  input  wire logic [COEF_IDX_W-1:0]                 cfg_idx_i,
  input  wire logic [Q15_W-1:0]                      cfg_data_i
);

  localparam int ACC_W = PROD_W + $clog2(TAPS);
  localparam int CNT_W = $clog2(TAPS);

  localparam prod_t                   RND_HALF = PROD_W'(16384);
  localparam prod_t                   P_HI     = PROD_W'(32767);
  localparam prod_t                   P_LO     = -PROD_W'(32768);
  localparam logic signed [ACC_W-1:0] A_HI     = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] A_LO     = -ACC_W'(32768);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_TERM = 5'b00100,
    S_SUM  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  q15_t coef_q [NUM_COEF];
  q15_t hist_q [LAG];
  prod_t prod_q;

  logic in_xfer;
  q15_t aligned;
  q15_t x_q15;
  prod_t rnd;
  q15_t p_rnd;

  cell_ctrl_t ctrl;
  q15_t                    chain_prod [TAPS+1];
  logic signed [ACC_W-1:0] chain_sum  [TAPS+1];
  logic signed [ACC_W-1:0] acc_shr;
  q15_t                    out_sat;

  logic           m_valid_q;
  logic [Q15_W-1:0] m_data_q;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  // Offset binary to Q1.15
  generate
    if (SAMPLE_BITS >= Q15_W) begin : g_wide
      assign aligned = s_axis_tdata[SAMPLE_BITS-1 -: Q15_W];
    end else begin : g_narrow
      assign aligned = {s_axis_tdata[SAMPLE_BITS-1:0], {(Q15_W-SAMPLE_BITS){1'b0}}};
    end
  endgenerate
  assign x_q15 = {~aligned[Q15_W-1], aligned[Q15_W-2:0]};

  // Coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEF; i++) coef_q[i] <= COEF_RESET[i];
    end else if (cfg_we_i && (cfg_idx_i < COEF_IDX_W'(NUM_COEF))) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Sample delay line, [0] is the oldest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAG; i++) hist_q[i] <= '0;
    end else if (in_xfer) begin
      for (int i = 0; i < LAG - 1; i++) hist_q[i] <= hist_q[i+1];
      hist_q[LAG-1] <= x_q15;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      prod_q <= PROD_W'(x_q15 * hist_q[0]);
    end
  end

  // Round half up to Q1.15 and saturate
  always_comb begin
    rnd = (prod_q + RND_HALF) >>> 15;
    if (rnd > P_HI) begin
      p_rnd = q15_t'(P_HI);
    end else if (rnd < P_LO) begin
      p_rnd = q15_t'(P_LO);
    end else begin
      p_rnd = q15_t'(rnd);
    end
  end

  // Tap chain
  assign ctrl.shift     = (state_q == S_MUL);
  assign ctrl.load_term = (state_q == S_TERM);
  assign chain_prod[0]  = p_rnd;
  assign chain_sum[0]   = '0;

  generate
    for (genvar k = 0; k < TAPS; k++) begin : g_tap
      localparam int MIRROR = (k < TAPS - 1 - k) ? k : TAPS - 1 - k;
      localparam int CI     = (MIRROR > NUM_COEF - 1) ? NUM_COEF - 1 : MIRROR;
      dmfd_cell #(.ACC_W(ACC_W)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl),
        .prod_i (chain_prod[k]),
        .coef_i (coef_q[CI]),
        .sum_i  (chain_sum[k]),
        .prod_o (chain_prod[k+1]),
        .sum_o  (chain_sum[k+1])
      );
    end
  endgenerate

  // Output scale and saturate
  always_comb begin
    acc_shr = chain_sum[TAPS] >>> 15;
    if (acc_shr > A_HI) begin
      out_sat = q15_t'(A_HI);
    end else if (acc_shr < A_LO) begin
      out_sat = q15_t'(A_LO);
    end else begin
      out_sat = q15_t'(acc_shr);
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: if (in_xfer) state_d = S_MUL;
      S_MUL:  state_d = S_TERM;
      S_TERM: begin
        state_d = S_SUM;
        cnt_d   = '0;
      end
      S_SUM: begin
        if (cnt_q == CNT_W'(TAPS - 1)) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DONE: if (!m_valid_q || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == S_DONE && (!m_valid_q || m_axis_tready)) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= out_sat;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `DMFD_ASSERT(a_accept_starts, in_xfer |=> state_q == S_MUL)
  `DMFD_ASSERT(a_done_holds, (state_q == S_DONE && m_valid_q && !m_axis_tready) |=> state_q == S_DONE)
  `DMFD_ASSERT(a_cnt_bound, state_q == S_SUM |-> cnt_q < CNT_W'(TAPS))
  `DMFD_ASSERT(a_cfg_write, (cfg_we_i && cfg_idx_i == '0) |=> coef_q[0] == $past(cfg_data_i))

endmodule
`default_nettype wire
